>>> hw/rtl/pee_pkg.sv
`timescale 1ns / 1ps
package pee_pkg;

  // number format
  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int KIND_WIDTH    = 3;

  // magnitude of a product or quotient after the fraction alignment
  localparam int MAG_W = VALUE_WIDTH + FRACTION_BITS;
  localparam int CNT_W = $clog2(MAG_W);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        mag_t;
  typedef logic [MAG_W-1:0]              wide_mag_t;

  localparam wide_mag_t POS_LIM = (MAG_W'(1) << (VALUE_WIDTH - 1)) - MAG_W'(1);
  localparam wide_mag_t NEG_LIM = MAG_W'(1) << (VALUE_WIDTH - 1);
  localparam value_t    VAL_MAX = value_t'(POS_LIM[VALUE_WIDTH-1:0]);
  localparam value_t    VAL_MIN = value_t'(NEG_LIM[VALUE_WIDTH-1:0]);

  // operator codes of an input item
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_END = 3'd4
  } kind_e;

  // pending operator codes
  typedef enum logic [1:0] {
    OP_POS = 2'd0,
    OP_NEG = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic commit;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_e  pend;
    logic div_zero;
    logic div_last;
    logic kind_end;
  } status_t;

  // saturated value with overflow indication
  typedef struct packed {
    value_t value;
    logic   ov;
  } sat_t;

  function automatic mag_t magnitude(value_t v);
    mag_t m;
    m = v[VALUE_WIDTH-1] ? (~mag_t'(v) + mag_t'(1)) : mag_t'(v);
    return m;
  endfunction

  // build a saturated value from sign and magnitude
  function automatic sat_t sat_mag(logic neg, wide_mag_t mag);
    sat_t      r;
    wide_mag_t lim;
    wide_mag_t m;
    lim  = neg ? NEG_LIM : POS_LIM;
    m    = mag;
    r.ov = 1'b0;
    if (mag > lim) begin
      r.ov = 1'b1;
      m    = lim;
    end
    r.value = neg ? value_t'(~m[VALUE_WIDTH-1:0] + mag_t'(1))
                  : value_t'(m[VALUE_WIDTH-1:0]);
    return r;
  endfunction

  function automatic sat_t sat_add(value_t a, value_t b);
    sat_t                     r;
    logic signed [VALUE_WIDTH:0] s;
    s    = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    r.ov = s[VALUE_WIDTH] != s[VALUE_WIDTH-1];
    if (r.ov) begin
      r.value = s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end else begin
      r.value = value_t'(s[VALUE_WIDTH-1:0]);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pee_stream_if.sv
`timescale 1ns / 1ps
// operand channel
interface pee_in_if;
  import pee_pkg::*;
  logic   valid;
  logic   ready;
  value_t operand;
  logic [KIND_WIDTH-1:0] kind;

  modport source (output valid, output operand, output kind, input ready);
  modport sink   (input valid, input operand, input kind, output ready);
endinterface

// result channel
interface pee_out_if;
  import pee_pkg::*;
  logic   valid;
  logic   ready;
  value_t result;
  logic   divide_by_zero;
  logic   overflow;

  modport source (output valid, output result, output divide_by_zero, output overflow,
                  input ready);
  modport sink   (input valid, input result, input divide_by_zero, input overflow,
                  output ready);
endinterface

>>> hw/rtl/pee_datapath.sv
`timescale 1ns / 1ps
module pee_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pee_pkg::cmd_t               cmd_i,
  output pee_pkg::status_t            status_o,
  input  pee_pkg::value_t             operand_i,
  input  logic [pee_pkg::KIND_WIDTH-1:0] kind_i,
  output pee_pkg::value_t             result_o,
  output logic                        divide_by_zero_o,
  output logic                        overflow_o
);
  import pee_pkg::*;

  // architectural state
  value_t sum_q, sum_d;
  value_t term_q, term_d;
  op_e    pend_q, pend_d;
  logic   dz_q, dz_d;
  logic   ov_q, ov_d;

  // captured item
  value_t x_q;
  logic [KIND_WIDTH-1:0] kind_q;

  // multiply and divide working registers
  logic [2*VALUE_WIDTH-1:0] prod_q, prod_d;
  logic      sign_q, sign_d;
  wide_mag_t qd_q, qd_d;
  mag_t      rem_q, rem_d;
  mag_t      dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // result register
  value_t res_q, res_d;
  logic   odz_q, odz_d;
  logic   oov_q, oov_d;

  mag_t mag_t_term;
  mag_t mag_x;
  sat_t neg_sat;
  sat_t mul_sat;
  sat_t div_sat;
  sat_t add_sat;
  logic [VALUE_WIDTH:0] div_r;
  logic                 div_ge;
  logic [VALUE_WIDTH:0] div_diff;

  assign mag_t_term = magnitude(term_q);
  assign mag_x      = magnitude(x_q);
  assign neg_sat    = sat_mag(~x_q[VALUE_WIDTH-1], wide_mag_t'(mag_x));
  assign mul_sat    = sat_mag(sign_q, prod_q[2*VALUE_WIDTH-1:FRACTION_BITS]);
  assign div_sat    = sat_mag(sign_q, qd_q);
  assign add_sat    = sat_add(sum_q, term_q);

  // one restoring divide step
  assign div_r    = {rem_q, qd_q[MAG_W-1]};
  assign div_ge   = div_r >= {1'b0, dsr_q};
  assign div_diff = div_r - {1'b0, dsr_q};

  assign status_o.pend     = pend_q;
  assign status_o.div_zero = (x_q == '0);
  assign status_o.div_last = (cnt_q == CNT_W'(MAG_W - 1));
  assign status_o.kind_end = (kind_q != KIND_ADD) && (kind_q != KIND_SUB) &&
                             (kind_q != KIND_MUL) && (kind_q != KIND_DIV);

  // next state of the expression registers
  always_comb begin
    sum_d  = sum_q;
    term_d = term_q;
    pend_d = pend_q;
    dz_d   = dz_q;
    ov_d   = ov_q;
    prod_d = prod_q;
    sign_d = sign_q;
    qd_d   = qd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    odz_d  = odz_q;
    oov_d  = oov_q;

    if (cmd_i.eval) begin
      case (pend_q)
        OP_POS: term_d = x_q;
        OP_NEG: begin
          term_d = neg_sat.value;
          ov_d   = ov_q | neg_sat.ov;
        end
        OP_MUL: begin
          prod_d = mag_t_term * mag_x;
          sign_d = term_q[VALUE_WIDTH-1] ^ x_q[VALUE_WIDTH-1];
        end
        OP_DIV: begin
          sign_d = term_q[VALUE_WIDTH-1] ^ x_q[VALUE_WIDTH-1];
          qd_d   = {mag_t_term, {FRACTION_BITS{1'b0}}};
          rem_d  = '0;
          dsr_d  = mag_x;
          cnt_d  = '0;
          if (x_q == '0) begin
            term_d = term_q[VALUE_WIDTH-1] ? VAL_MIN : VAL_MAX;
            dz_d   = 1'b1;
          end
        end
        default: term_d = x_q;
      endcase
    end

    if (cmd_i.mul_fin) begin
      term_d = mul_sat.value;
      ov_d   = ov_q | mul_sat.ov;
    end

    if (cmd_i.div_step) begin
      rem_d = div_ge ? div_diff[VALUE_WIDTH-1:0] : div_r[VALUE_WIDTH-1:0];
      qd_d  = {qd_q[MAG_W-2:0], div_ge};
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (cmd_i.div_fin) begin
      term_d = div_sat.value;
      ov_d   = ov_q | div_sat.ov;
    end

    // fold the term into the sum or just record the next operator
    if (cmd_i.commit) begin
      pend_d = op_e'(kind_q[1:0]);
      if ((kind_q == KIND_ADD) || (kind_q == KIND_SUB)) begin
        sum_d  = add_sat.value;
        ov_d   = ov_q | add_sat.ov;
        term_d = '0;
      end
    end

    // end of expression: load result and clear state
    if (cmd_i.finish) begin
      res_d  = add_sat.value;
      odz_d  = dz_q;
      oov_d  = ov_q | add_sat.ov;
      sum_d  = '0;
      term_d = '0;
      pend_d = OP_POS;
      dz_d   = 1'b0;
      ov_d   = 1'b0;
    end
  end

  // expression state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      term_q <= '0;
      pend_q <= OP_POS;
      dz_q   <= 1'b0;
      ov_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      term_q <= term_d;
      pend_q <= pend_d;
      dz_q   <= dz_d;
      ov_q   <= ov_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= operand_i;
      kind_q <= kind_i;
    end
    prod_q <= prod_d;
    sign_q <= sign_d;
    qd_q   <= qd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    res_q  <= res_d;
    odz_q  <= odz_d;
    oov_q  <= oov_d;
  end

  assign result_o         = res_q;
  assign divide_by_zero_o = odz_q;
  assign overflow_o       = oov_q;

endmodule

>>> hw/rtl/pee_controller.sv
`timescale 1ns / 1ps
module pee_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pee_pkg::status_t status_i,
  output pee_pkg::cmd_t    cmd_o
);
  import pee_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_MULX = 6'b000100,
    S_DIV  = 6'b001000,
    S_DIVX = 6'b010000,
    S_ADD  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;
  logic   out_busy;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;

  // sequencing of one item
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        case (status_i.pend)
          OP_MUL:  state_d = S_MULX;
          OP_DIV:  state_d = status_i.div_zero ? S_ADD : S_DIV;
          default: state_d = S_ADD;
        endcase
      end
      S_MULX: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = S_ADD;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_ADD;
      end
      S_ADD: begin
        if (!status_i.kind_end) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else if (!out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result slot: set on finish, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded while output slot busy");

  // a finish always presents a result next cycle
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finish did not raise output valid");

  // an accepted item is evaluated in the following cycle
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EVAL))
    else $error("accepted item not evaluated");

  // the last divide step leads to quotient saturation
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && status_i.div_last) |=> (state_q == S_DIVX))
    else $error("divide did not terminate after last step");

endmodule

>>> hw/rtl/precedence_expression_evaluator.sv
`timescale 1ns / 1ps
// precedence expression evaluator
//
// in_i carries one operand (signed Q16.16) and the operator that follows it:
// add, subtract, multiply, divide or end of expression. Multiply and divide
// bind first; both levels run left to right. out_o gives one result per end
// mark: the saturated Q16.16 value and sticky divide-by-zero and overflow
// flags for that expression.
// One item is taken at a time. Add, subtract and a leading term run an
// evaluate step and an add step; a multiply puts one 32x32 magnitude
// multiply, then saturation, between them; a divide puts the restoring
// divider that retires one quotient bit per cycle over 48 bits, then
// saturation; a zero divisor skips the divider. The result appears in the
// cycle after the end-mark item finishes.
// The result sits in an output register; new items are accepted while it
// waits. If the receiver stalls, an end-mark item waits in its last step
// until the pending result is taken, and input ready stays low meanwhile.
// Reset clears the sum, the term, the pending operator, the flags and the
// output valid; no clearing pass is needed.
module precedence_expression_evaluator (
  input  logic      clk_i,
  input  logic      rst_ni,
  pee_in_if.sink    in_i,
  pee_out_if.source out_o
);
  import pee_pkg::*;

  cmd_t    cmd;
  status_t status;

  pee_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pee_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operand_i        (in_i.operand),
    .kind_i           (in_i.kind),
    .result_o         (out_o.result),
    .divide_by_zero_o (out_o.divide_by_zero),
    .overflow_o       (out_o.overflow)
  );

endmodule

>>> verif/precedence_expression_evaluator_tb.sv
`timescale 1ns / 1ps
module precedence_expression_evaluator_tb;
  import pee_pkg::*;

  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     RANDOM_ITEMS  = 2000;
  localparam int     CALM_TAIL     = 200;
  localparam int     DRAIN_CYCLES  = 64;
  localparam int     KIND_CODE_MAX = 2 ** KIND_WIDTH - 1;
  localparam value_t ONE           = value_t'(32'h0001_0000);

  typedef struct packed {
    value_t                operand;
    logic [KIND_WIDTH-1:0] kind;
  } expr_token_t;

  typedef struct packed {
    value_t value;
    logic   dz;
    logic   ov;
  } expr_outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // driven copies of the channel inputs, known from time zero
  logic                  op_valid = 1'b0;
  value_t                op_value = '0;
  logic [KIND_WIDTH-1:0] op_kind  = KIND_ADD;
  logic                  res_ready = 1'b0;

  pee_in_if  in_if ();
  pee_out_if out_if ();

  assign in_if.valid   = op_valid;
  assign in_if.operand = op_value;
  assign in_if.kind    = op_kind;
  assign out_if.ready  = res_ready;

  precedence_expression_evaluator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  expr_token_t   token_q[$];
  expr_outcome_t outcome_q[$];
  int            bad_results = 0;
  int            cycle_count = 0;

  // evaluator state mirrored in the testbench
  value_t run_sum  = '0;
  value_t run_term = '0;
  op_e    run_op   = OP_POS;
  logic   dz_flag  = 1'b0;
  logic   ov_flag  = 1'b0;

  function automatic logic [63:0] mag_of(value_t v);
    longint lv;
    lv = longint'(v);
    return lv < 0 ? 64'(-lv) : 64'(lv);
  endfunction

  // clamp a signed magnitude to the Q16.16 range
  function automatic value_t clamp_q(logic neg, logic [63:0] mag);
    logic [63:0] lim;
    lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    if (mag > lim) begin
      ov_flag = 1'b1;
      mag     = lim;
    end
    return neg ? value_t'(~mag[31:0] + 32'd1) : value_t'(mag[31:0]);
  endfunction

  function automatic value_t sum_q(value_t a, value_t b);
    longint s;
    s = longint'(a) + longint'(b);
    return clamp_q(s < 0, s < 0 ? 64'(-s) : 64'(s));
  endfunction

  function automatic value_t negate_q(value_t x);
    return clamp_q(!x[VALUE_WIDTH-1], mag_of(x));
  endfunction

  // magnitude product, truncated toward zero
  function automatic value_t product_q(value_t a, value_t b);
    return clamp_q(a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1],
                   (mag_of(a) * mag_of(b)) >> FRACTION_BITS);
  endfunction

  // magnitude quotient; zero divisor saturates by dividend sign
  function automatic value_t quotient_q(value_t a, value_t b);
    if (b == '0) begin
      dz_flag = 1'b1;
      return a[VALUE_WIDTH-1] ? VAL_MIN : VAL_MAX;
    end
    return clamp_q(a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1],
                   (mag_of(a) << FRACTION_BITS) / mag_of(b));
  endfunction

  // fold one accepted operand into the expression, queue the value on an end mark
  task automatic absorb_operand(value_t x, logic [KIND_WIDTH-1:0] k);
    expr_outcome_t done;
    case (run_op)
      OP_POS:  run_term = x;
      OP_NEG:  run_term = negate_q(x);
      OP_MUL:  run_term = product_q(run_term, x);
      default: run_term = quotient_q(run_term, x);
    endcase
    if (k == KIND_ADD || k == KIND_SUB) begin
      run_sum  = sum_q(run_sum, run_term);
      run_term = '0;
      run_op   = (k == KIND_ADD) ? OP_POS : OP_NEG;
    end else if (k == KIND_MUL || k == KIND_DIV) begin
      run_op = (k == KIND_MUL) ? OP_MUL : OP_DIV;
    end else begin
      done.value = sum_q(run_sum, run_term);
      done.dz    = dz_flag;
      done.ov    = ov_flag;
      outcome_q.push_back(done);
      run_sum  = '0;
      run_term = '0;
      run_op   = OP_POS;
      dz_flag  = 1'b0;
      ov_flag  = 1'b0;
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // operand driver
  int send_gap      = 0;
  int send_idle_pct = 10;
  int sent_count    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid <= 1'b0;
      op_value <= '0;
      op_kind  <= KIND_ADD;
      send_gap <= 0;
    end else if (!op_valid || in_if.ready) begin
      if (op_valid) begin
        absorb_operand(in_if.operand, in_if.kind);
      end
      if (send_gap != 0) begin
        op_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (token_q.size() == 0) begin
        op_valid <= 1'b0;
      end else if (token_q.size() > CALM_TAIL && $urandom_range(99) < send_idle_pct) begin
        op_valid <= 1'b0;
        send_gap <= $urandom_range(3);
      end else begin
        op_value <= token_q[0].operand;
        op_kind  <= token_q[0].kind;
        op_valid <= 1'b1;
        token_q.delete(0);
        sent_count <= sent_count + 1;
        if (sent_count % 128 == 127) begin
          send_idle_pct <= pick_idle_pct();
        end
      end
    end
  end

  // result monitor with random receiver stalls
  int recv_stall    = 0;
  int recv_idle_pct = 10;
  int recv_count    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_if.valid && res_ready) begin
        recv_count <= recv_count + 1;
        if (recv_count % 16 == 15) begin
          recv_idle_pct <= pick_idle_pct();
        end
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h dz %b ov %b", $time,
                   out_if.result, out_if.divide_by_zero, out_if.overflow);
          bad_results++;
        end else begin
          if (out_if.result !== outcome_q[0].value) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time,
                     outcome_q[0].value, out_if.result);
            bad_results++;
          end
          if (out_if.divide_by_zero !== outcome_q[0].dz) begin
            $display("%0t: divide_by_zero mismatch, expected %b, actual %b", $time,
                     outcome_q[0].dz, out_if.divide_by_zero);
            bad_results++;
          end
          if (out_if.overflow !== outcome_q[0].ov) begin
            $display("%0t: overflow mismatch, expected %b, actual %b", $time,
                     outcome_q[0].ov, out_if.overflow);
            bad_results++;
          end
          outcome_q.delete(0);
        end
      end
      if (recv_stall != 0) begin
        res_ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (token_q.size() > CALM_TAIL && $urandom_range(99) < recv_idle_pct) begin
        res_ready  <= 1'b0;
        recv_stall <= $urandom_range(3);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("precedence_expression_evaluator_tb: FAIL");
      $finish;
    end
  end

  function automatic value_t pick_operand();
    value_t v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = VAL_MAX;
      2: v = VAL_MIN;
      3, 4: begin
        v = value_t'($urandom_range(0, 32'h000F_FFFF));
        if ($urandom_range(1)) v = -v;
      end
      5: v = value_t'($signed(16'($urandom)));
      9: v = $urandom_range(1) ? value_t'(1) : value_t'(-1);
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int                    len;
    logic [KIND_WIDTH-1:0] k;

    // saturating add, negated most negative value, product overflow
    token_q.push_back('{VAL_MAX, KIND_ADD});
    token_q.push_back('{VAL_MAX, KIND_END});
    token_q.push_back('{'0, KIND_SUB});
    token_q.push_back('{VAL_MIN, KIND_END});
    token_q.push_back('{VAL_MAX, KIND_MUL});
    token_q.push_back('{VAL_MAX, KIND_END});
    token_q.push_back('{VAL_MIN, KIND_MUL});
    token_q.push_back('{VAL_MIN, KIND_END});
    // zero divisor with positive, negative and zero dividend
    token_q.push_back('{value_t'(5 * ONE), KIND_DIV});
    token_q.push_back('{'0, KIND_END});
    token_q.push_back('{value_t'(-5 * ONE), KIND_DIV});
    token_q.push_back('{'0, KIND_END});
    token_q.push_back('{'0, KIND_DIV});
    token_q.push_back('{'0, KIND_END});
    // 1 + 2 * 3 - 4 / 2
    token_q.push_back('{ONE, KIND_ADD});
    token_q.push_back('{value_t'(2 * ONE), KIND_MUL});
    token_q.push_back('{value_t'(3 * ONE), KIND_SUB});
    token_q.push_back('{value_t'(4 * ONE), KIND_DIV});
    token_q.push_back('{value_t'(2 * ONE), KIND_END});
    // unused kind codes close the expression
    token_q.push_back('{value_t'(-1), KIND_WIDTH'(KIND_END + 1)});
    token_q.push_back('{VAL_MAX, KIND_WIDTH'(KIND_END + 2)});
    token_q.push_back('{VAL_MIN, KIND_WIDTH'(KIND_END + 3)});
    // quotient overflow
    token_q.push_back('{VAL_MIN, KIND_DIV});
    token_q.push_back('{value_t'(ONE / 2), KIND_END});

    // random expressions, mostly short
    while (token_q.size() < RANDOM_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) begin
          k = ($urandom_range(19) == 0) ? KIND_WIDTH'($urandom_range(KIND_END + 1, KIND_CODE_MAX))
                                        : KIND_END;
        end else begin
          case ($urandom_range(3))
            0:       k = KIND_ADD;
            1:       k = KIND_SUB;
            2:       k = KIND_MUL;
            default: k = KIND_DIV;
          endcase
        end
        token_q.push_back('{pick_operand(), k});
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (token_q.size() != 0 || op_valid || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (bad_results == 0) begin
      $display("precedence_expression_evaluator_tb: PASS");
    end else begin
      $display("precedence_expression_evaluator_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pee_pkg.sv
hw/rtl/pee_stream_if.sv
hw/rtl/pee_datapath.sv
hw/rtl/pee_controller.sv
hw/rtl/precedence_expression_evaluator.sv
verif/precedence_expression_evaluator_tb.sv
